// ----- src/sacl_pkg.sv -----
// Shared types and constants of the set-associative cache LRU controller.
// No dependencies.
`timescale 1ns / 1ps
package sacl_pkg;
   localparam int WAYS        = 4;
   localparam int SETS        = 64;
   localparam int BLOCK_BYTES = 16;
   localparam int WAY_BITS    = $clog2(WAYS);
   localparam int SET_BITS    = $clog2(SETS);
   localparam int OFF_BITS    = $clog2(BLOCK_BYTES);
   localparam int TAG_BITS    = 32 - SET_BITS - OFF_BITS;
   localparam int LINES       = WAYS * SETS;
   localparam int LINE_BITS   = $clog2(LINES);
   // one way of a row: {age, dirty, tag}
   localparam int WAY_ROW_W   = TAG_BITS + 1 + WAY_BITS;
   localparam int ROW_W       = WAY_ROW_W * WAYS;

   localparam logic [1:0] POLICY_READ_ONLY    = 2'd0;
   localparam logic [1:0] POLICY_WRITE_THRU   = 2'd1;
   localparam logic [1:0] POLICY_WRITE_BACK   = 2'd2;

   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   typedef struct packed {
      logic        action;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [1:0]  way;
      logic        fill_request;
      logic [31:0] fill_address;
      logic        writeback_request;
      logic [31:0] writeback_address;
      logic        memory_word_write;
      logic [31:0] access_total;
      logic [31:0] miss_total;
      logic [31:0] dirty_replace_total;
      logic [31:0] clean_replace_total;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic decide;
      logic emit;
   } ctl_type;
endpackage

// ----- src/sacl_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ----- src/sacl_ctrl.sv -----
// Sequencer: capture, tag read, decide/update, emit.
// Depends on sacl_pkg.
`timescale 1ns / 1ps
module sacl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output sacl_pkg::ctl_type ctl
);
   import sacl_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DEC  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   // advance one step per cycle, waiting in idle until start
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_READ;
         ST_READ: state_in = ST_DEC;
         ST_DEC:  state_in = ST_EMIT;
         ST_EMIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign busy        = state_ff != ST_IDLE;
   assign ctl.capture = start && state_ff == ST_IDLE;
   assign ctl.decide  = state_ff == ST_DEC;
   assign ctl.emit    = state_ff == ST_EMIT;

   ap_start: assert property (@(posedge clock) disable iff (reset)
      ctl.capture |=> state_ff == ST_READ) else $error("no read after start");
   ap_emit: assert property (@(posedge clock) disable iff (reset)
      ctl.decide |=> ctl.emit) else $error("no emit after decide");
   ap_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |=> !busy) else $error("busy after emit");
endmodule

// ----- src/sacl_dp.sv -----
// Datapath: tag/dirty/LRU row RAM, valid flops, victim choice, counters.
// Depends on sacl_pkg and sacl_ram.
`timescale 1ns / 1ps
module sacl_dp (
   input  logic              clock,
   input  logic              reset,
   input  sacl_pkg::ctl_type ctl,
   input  sacl_pkg::req_type req,
   input  logic [1:0]        policy,
   output sacl_pkg::rsp_type rsp_ff
);
   import sacl_pkg::*;

   logic                 act_ff;
   logic [31:0]          addr_ff;
   logic [LINES-1:0]     valid_ff, valid_in;
   logic [31:0]          acc_ff, miss_ff, drep_ff, crep_ff;
   logic [31:0]          acc_in, miss_in, drep_in, crep_in;
   rsp_type              rsp_in;
   logic [ROW_W-1:0]     row_rd, row_wr;
   logic                 row_we;
   logic [SET_BITS-1:0]  set_idx, ram_set;
   logic [TAG_BITS-1:0]  tag;
   logic [LINE_BITS-1:0] base;
   logic                 set_seen;
   logic [WAYS-1:0]      way_valid;
   logic [WAYS-1:0]      way_dirty;
   logic [TAG_BITS-1:0]  way_tag [WAYS];
   logic [WAY_BITS-1:0]  way_age [WAYS];

   assign set_idx = addr_ff[OFF_BITS +: SET_BITS];
   assign tag     = addr_ff[31 -: TAG_BITS];
   assign base    = LINE_BITS'(set_idx) << WAY_BITS;
   assign ram_set = ctl.capture ? req.address[OFF_BITS +: SET_BITS] : set_idx;

   sacl_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_tags (
      .clock(clock), .wr_en(row_we), .addr(ram_set),
      .wr_data(row_wr), .rd_data(row_rd));

   // capture the request beat
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         act_ff  <= req.action;
         addr_ff <= req.address;
      end
   end

   // unpack the row; a set with no valid way reads each way's index as its age
   always_comb begin
      set_seen = |valid_ff[base +: WAYS];
      for (int i = 0; i < WAYS; i++) begin
         way_valid[i] = valid_ff[base + LINE_BITS'(i)];
         way_tag[i]   = row_rd[i*WAY_ROW_W +: TAG_BITS];
         way_dirty[i] = row_rd[i*WAY_ROW_W + TAG_BITS];
         way_age[i]   = set_seen ? row_rd[i*WAY_ROW_W + TAG_BITS + 1 +: WAY_BITS]
                                 : WAY_BITS'(i);
      end
   end

   // lookup, victim choice and state update
   always_comb begin
      logic                found, alloc, vd;
      logic [WAY_BITS-1:0] hw, vw, uw, a;
      logic                vfound;
      logic                wr;
      wr       = act_ff == ACTION_WRITE;
      valid_in = valid_ff;
      acc_in   = acc_ff;
      miss_in  = miss_ff;
      drep_in  = drep_ff;
      crep_in  = crep_ff;
      row_wr   = row_rd;
      row_we   = 1'b0;
      rsp_in   = rsp_ff;
      found    = 1'b0;
      hw       = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (way_valid[i] && way_tag[i] == tag) begin
            found = 1'b1;
            hw    = WAY_BITS'(i);
         end
      end
      vfound = 1'b0;
      vw     = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (!way_valid[i]) begin
            vfound = 1'b1;
            vw     = WAY_BITS'(i);
         end
      end
      if (!vfound) begin
         for (int i = WAYS - 1; i >= 0; i--) begin
            if (way_age[i] == WAY_BITS'(WAYS - 1)) vw = WAY_BITS'(i);
         end
      end
      alloc = !found && !(wr && policy != POLICY_WRITE_BACK);
      vd    = way_valid[vw] && way_dirty[vw];
      uw    = found ? hw : vw;
      a     = way_age[uw];
      if (ctl.decide) begin
         acc_in = acc_ff + 32'd1;
         if (!found) miss_in = miss_ff + 32'd1;
         // touch LRU for hit or allocation and write the row back
         if (found || alloc) begin
            row_we = 1'b1;
            for (int i = 0; i < WAYS; i++) begin
               row_wr[i*WAY_ROW_W + TAG_BITS + 1 +: WAY_BITS] =
                  (way_age[i] < a) ? way_age[i] + 1'b1 : way_age[i];
            end
            row_wr[uw*WAY_ROW_W + TAG_BITS + 1 +: WAY_BITS] = '0;
         end
         if (found && wr && policy == POLICY_WRITE_BACK)
            row_wr[hw*WAY_ROW_W + TAG_BITS] = 1'b1;
         if (alloc) begin
            if (vd) drep_in = drep_ff + 32'd1;
            else    crep_in = crep_ff + 32'd1;
            valid_in[base + LINE_BITS'(vw)] = 1'b1;
            row_wr[vw*WAY_ROW_W + TAG_BITS]    = wr;
            row_wr[vw*WAY_ROW_W +: TAG_BITS]   = tag;
         end
         rsp_in.hit               = found;
         rsp_in.way               = found ? 2'(hw) : (alloc ? 2'(vw) : 2'd0);
         rsp_in.fill_request      = alloc;
         rsp_in.fill_address      = alloc ? {addr_ff[31:OFF_BITS], {OFF_BITS{1'b0}}} : 32'd0;
         rsp_in.writeback_request = alloc && vd;
         rsp_in.writeback_address = (alloc && vd) ?
            {way_tag[vw], set_idx, {OFF_BITS{1'b0}}} : 32'd0;
         rsp_in.memory_word_write = wr && policy == POLICY_WRITE_THRU;
         rsp_in.access_total        = acc_in;
         rsp_in.miss_total          = miss_in;
         rsp_in.dirty_replace_total = drep_in;
         rsp_in.clean_replace_total = crep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         acc_ff   <= '0;
         miss_ff  <= '0;
         drep_ff  <= '0;
         crep_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         acc_ff   <= acc_in;
         miss_ff  <= miss_in;
         drep_ff  <= drep_in;
         crep_ff  <= crep_in;
      end
      rsp_ff <= rsp_in;
   end

   ap_acc: assert property (@(posedge clock) disable iff (reset)
      ctl.decide |=> acc_ff == $past(acc_ff) + 32'd1) else $error("access count");
   ap_fill: assert property (@(posedge clock) disable iff (reset)
      ctl.emit && rsp_ff.fill_request |-> !rsp_ff.hit) else $error("fill on hit");
   ap_wb: assert property (@(posedge clock) disable iff (reset)
      ctl.emit && rsp_ff.writeback_request |-> rsp_ff.fill_request) else $error("wb no fill");
endmodule

// ----- src/set_assoc_cache_lru_controller_core.sv -----
// Top level of the set-associative cache LRU controller.
// Depends on sacl_pkg, sacl_ctrl, sacl_dp.
`timescale 1ns / 1ps
// Usage:
//  - Pulse start with req_payload while busy is low; the beat is taken then.
//  - Busy stays high while the set's tag/dirty/age row is read from the RAM,
//    then hit/victim are decided and the row written back, then the result
//    beat appears on rsp_payload with rsp_valid high for exactly one cycle.
//  - Accesses do not overlap: each passes the accepting step, the registered
//    RAM read, the decide step that registers the result, and the result step.
//  - Results cannot be stalled; the receiver must take each one.
//  - CSR write_policy at byte 0 (APB, pready always high), reset 2.
//    Write it only while busy is low.
//  - Synchronous reset clears valid, counters and busy. Dirty bits, tags and
//    ages live in the RAM: dirty and tag are only read for valid lines, and a
//    set with no valid line reads each way's index as its age, so no clearing
//    pass is needed.
module set_assoc_cache_lru_controller_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sacl_pkg::req_type req_payload,
   output logic              rsp_valid,
   output sacl_pkg::rsp_type rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic              csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import sacl_pkg::*;

   ctl_type    ctl;
   logic [1:0] policy_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = {30'd0, policy_ff};

   // register write on access phase; writes to the second word are ignored
   always_ff @(posedge clock) begin
      if (reset) policy_ff <= POLICY_WRITE_BACK;
      else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr)
         policy_ff <= csr_pwdata[1:0];
   end

   sacl_ctrl u_ctrl (.clock(clock), .reset(reset), .start(start), .busy(busy), .ctl(ctl));
   sacl_dp u_dp (.clock(clock), .reset(reset), .ctl(ctl), .req(req_payload),
      .policy(policy_ff), .rsp_ff(rsp_payload));

   assign rsp_valid = ctl.emit;
endmodule
